/* rtl/svs_pkg.sv */
// Shared types, codes and register map for the servo sweep block.
package svs_pkg;

    localparam int SAMPLE_W = 10;
    localparam int ANGLE_W  = 8;
    localparam int STEP_W   = 6;
    localparam int COUNT_W  = 8;
    localparam int MODE_W   = 2;
    localparam int ADDR_W   = 5;
    localparam int DATA_W   = 32;

    // mode codes, also the state of the back end
    localparam logic [MODE_W-1:0] MODE_START  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_SWEEP  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_MANUAL = 2'd2;
    localparam logic [MODE_W-1:0] MODE_IDLE   = 2'd3;

    // register indexes (byte address is 4 * index)
    localparam logic [2:0] REG_HIGH_THRESHOLD = 3'd0;
    localparam logic [2:0] REG_LOW_THRESHOLD  = 3'd1;
    localparam logic [2:0] REG_ANGLE_STEP     = 3'd2;
    localparam logic [2:0] REG_MAX_ANGLE      = 3'd3;
    localparam logic [2:0] REG_IDLE_TIMEOUT   = 3'd4;

    localparam logic [SAMPLE_W-1:0] HIGH_THRESHOLD_RST = 10'd600;
    localparam logic [SAMPLE_W-1:0] LOW_THRESHOLD_RST  = 10'd400;
    localparam logic [STEP_W-1:0]   ANGLE_STEP_RST     = 6'd5;
    localparam logic [ANGLE_W-1:0]  MAX_ANGLE_RST      = 8'd180;
    localparam logic [COUNT_W-1:0]  IDLE_TIMEOUT_RST   = 8'd20;

    localparam logic [COUNT_W-1:0]  COUNT_MAX = {COUNT_W{1'b1}};

    // stick classification carried from front to back
    typedef logic [1:0] cls_t;
    localparam cls_t CLS_CENTER = 2'd0;
    localparam cls_t CLS_HIGH   = 2'd1;
    localparam cls_t CLS_LOW    = 2'd2;

    localparam int QDEPTH = 2;
    localparam int QPTR_W = 1;
    localparam int QCNT_W = 2;

    typedef struct packed {
        logic [SAMPLE_W-1:0] high_threshold;
        logic [SAMPLE_W-1:0] low_threshold;
        logic [STEP_W-1:0]   angle_step;
        logic [ANGLE_W-1:0]  max_angle;
        logic [COUNT_W-1:0]  idle_timeout;
    } cfg_t;

    // queue handshake between front and back
    typedef struct packed {
        logic valid;
        cls_t cls;
    } q_word_t;

endpackage

/* rtl/svs_if.sv */
// Stream interfaces for stick samples and servo results.
interface svs_sample_if;
    logic                      valid;
    logic                      ready;
    logic [svs_pkg::SAMPLE_W-1:0] stick_sample;

    modport source (output valid, output stick_sample, input ready);
    modport sink   (input valid, input stick_sample, output ready);
endinterface

interface svs_result_if;
    logic                        valid;
    logic                        ready;
    logic [svs_pkg::ANGLE_W-1:0] servo_angle;
    logic [svs_pkg::MODE_W-1:0]  mode;

    modport source (output valid, output servo_angle, output mode, input ready);
    modport sink   (input valid, input servo_angle, input mode, output ready);
endinterface

/* rtl/servo_sweep_with_manual_override.sv */
// Top level of the servo sweep controller with manual stick override.
//
// Usage:
//   sample_ch carries one stick_sample word per tick (valid/ready).
//   result_ch returns one word per tick: servo_angle and mode
//   (1 sweep, 2 manual, 3 idle; start is never reported).
//   The APB port holds five registers at byte addresses 0x00..0x10:
//   high_threshold, low_threshold, angle_step, max_angle, idle_timeout.
//   Write them only while no tick is in flight; pready is tied high.
// Timing:
//   A sample passes the classify register, a two-entry queue and the
//   result register, in that order, before the result word goes valid.
//   One sample per cycle is sustained while result_ch.ready stays high;
//   the mode/angle update in the back end is combinational and is
//   registered with the result word.
// Reset:
//   rst_n clears the mode to start, angle and idle count to zero, the
//   sweep direction to up, and loads the register defaults.
// Stall:
//   When result_ch.ready is low the result word holds, the queue fills,
//   and sample_ch.ready drops once the queue and classify stage are full.
module servo_sweep_with_manual_override (
    input  logic                        clk,
    input  logic                        rst_n,
    svs_sample_if.sink                  sample_ch,
    svs_result_if.source                result_ch,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [svs_pkg::ADDR_W-1:0]  paddr,
    input  logic [svs_pkg::DATA_W-1:0]  pwdata,
    output logic [svs_pkg::DATA_W-1:0]  prdata,
    output logic                        pready
);
    import svs_pkg::*;

    cfg_t    cfg;
    q_word_t push;
    q_word_t head;
    logic    push_ready;
    logic    pop;

    svs_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    svs_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .sample_ch  (sample_ch),
        .push       (push),
        .push_ready (push_ready)
    );

    svs_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_ready (push_ready),
        .head       (head),
        .pop        (pop)
    );

    svs_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .head      (head),
        .pop       (pop),
        .result_ch (result_ch)
    );

endmodule

/* rtl/svs_regs.sv */
// APB configuration registers.
module svs_regs (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [svs_pkg::ADDR_W-1:0]  paddr,
    input  logic [svs_pkg::DATA_W-1:0]  pwdata,
    output logic [svs_pkg::DATA_W-1:0]  prdata,
    output logic                        pready,
    output svs_pkg::cfg_t               cfg
);
    import svs_pkg::*;

    cfg_t       cfg_reg;
    logic       wr_en;
    logic [2:0] idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign idx    = paddr[4:2];
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.high_threshold <= HIGH_THRESHOLD_RST;
            cfg_reg.low_threshold  <= LOW_THRESHOLD_RST;
            cfg_reg.angle_step     <= ANGLE_STEP_RST;
            cfg_reg.max_angle      <= MAX_ANGLE_RST;
            cfg_reg.idle_timeout   <= IDLE_TIMEOUT_RST;
        end
        else if (wr_en)
        begin
            unique case (idx)
                REG_HIGH_THRESHOLD: cfg_reg.high_threshold <= pwdata[SAMPLE_W-1:0];
                REG_LOW_THRESHOLD:  cfg_reg.low_threshold  <= pwdata[SAMPLE_W-1:0];
                REG_ANGLE_STEP:     cfg_reg.angle_step     <= pwdata[STEP_W-1:0];
                REG_MAX_ANGLE:      cfg_reg.max_angle      <= pwdata[ANGLE_W-1:0];
                REG_IDLE_TIMEOUT:   cfg_reg.idle_timeout   <= pwdata[COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        prdata = '0;
        unique case (idx)
            REG_HIGH_THRESHOLD: prdata = {{(DATA_W-SAMPLE_W){1'b0}}, cfg_reg.high_threshold};
            REG_LOW_THRESHOLD:  prdata = {{(DATA_W-SAMPLE_W){1'b0}}, cfg_reg.low_threshold};
            REG_ANGLE_STEP:     prdata = {{(DATA_W-STEP_W){1'b0}}, cfg_reg.angle_step};
            REG_MAX_ANGLE:      prdata = {{(DATA_W-ANGLE_W){1'b0}}, cfg_reg.max_angle};
            REG_IDLE_TIMEOUT:   prdata = {{(DATA_W-COUNT_W){1'b0}}, cfg_reg.idle_timeout};
            default:            prdata = '0;
        endcase
    end

endmodule

/* rtl/svs_front.sv */
// Front end: takes stick samples and classifies them against the thresholds.
module svs_front (
    input  logic             clk,
    input  logic             rst_n,
    input  svs_pkg::cfg_t    cfg,
    svs_sample_if.sink       sample_ch,
    output svs_pkg::q_word_t push,
    input  logic             push_ready
);
    import svs_pkg::*;

    logic valid_reg;
    logic valid_next;
    cls_t cls_reg;
    cls_t cls_next;
    logic take;

    assign sample_ch.ready = !valid_reg || push_ready;
    assign take            = sample_ch.valid && sample_ch.ready;

    // high test wins when both thresholds are crossed
    always_comb
    begin
        if (sample_ch.stick_sample > cfg.high_threshold)
            cls_next = CLS_HIGH;
        else if (sample_ch.stick_sample < cfg.low_threshold)
            cls_next = CLS_LOW;
        else
            cls_next = CLS_CENTER;
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (take)
            valid_next = 1'b1;
        else if (push_ready)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (take)
            cls_reg <= cls_next;
    end

    assign push.valid = valid_reg;
    assign push.cls   = cls_reg;

endmodule

/* rtl/svs_queue.sv */
// Short queue of classified samples between front and back.
module svs_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  svs_pkg::q_word_t push,
    output logic             push_ready,
    output svs_pkg::q_word_t head,
    input  logic             pop
);
    import svs_pkg::*;

    cls_t              mem [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;
    logic              do_push;
    logic              do_pop;

    assign push_ready = (count_reg != QCNT_W'(QDEPTH));
    assign do_push    = push.valid && push_ready;
    assign do_pop     = pop && (count_reg != '0);
    assign head.valid = (count_reg != '0);
    assign head.cls   = mem[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wr_ptr_reg] <= push.cls;
    end

endmodule

/* rtl/svs_back.sv */
// Back end: mode machine, angle update and the result register.
module svs_back (
    input  logic             clk,
    input  logic             rst_n,
    input  svs_pkg::cfg_t    cfg,
    input  svs_pkg::q_word_t head,
    output logic             pop,
    svs_result_if.source     result_ch
);
    import svs_pkg::*;

    logic [MODE_W-1:0]  mode_reg;
    logic [MODE_W-1:0]  mode_next;
    logic [ANGLE_W-1:0] position_reg;
    logic [ANGLE_W-1:0] position_next;
    logic               sweep_down_reg;
    logic               sweep_down_next;
    logic [COUNT_W-1:0] idle_count_reg;
    logic [COUNT_W-1:0] idle_count_next;
    logic               out_valid_reg;
    logic [ANGLE_W-1:0] out_angle_reg;
    logic [MODE_W-1:0]  out_mode_reg;

    logic               hi;
    logic               lo;
    logic               pushed;
    logic [ANGLE_W:0]   up_sum;
    logic               up_clamp;
    logic               down_clamp;
    logic [ANGLE_W-1:0] up_pos;
    logic [ANGLE_W-1:0] down_pos;

    assign pop    = head.valid && (!out_valid_reg || result_ch.ready);
    assign hi     = (head.cls == CLS_HIGH);
    assign lo     = (head.cls == CLS_LOW);
    assign pushed = hi || lo;

    assign up_sum     = {1'b0, position_reg} + {{(ANGLE_W+1-STEP_W){1'b0}}, cfg.angle_step};
    assign up_clamp   = (up_sum >= {1'b0, cfg.max_angle});
    assign down_clamp = ({1'b0, position_reg} <= {{(ANGLE_W+1-STEP_W){1'b0}}, cfg.angle_step});
    assign up_pos     = up_clamp ? cfg.max_angle : up_sum[ANGLE_W-1:0];
    assign down_pos   = down_clamp ? '0 : (position_reg - {{(ANGLE_W-STEP_W){1'b0}}, cfg.angle_step});

    always_comb
    begin
        mode_next       = mode_reg;
        idle_count_next = idle_count_reg;
        position_next   = position_reg;
        sweep_down_next = sweep_down_reg;

        unique case (mode_reg)
            MODE_START:  mode_next = MODE_SWEEP;
            MODE_SWEEP:  mode_next = pushed ? MODE_MANUAL : MODE_SWEEP;
            MODE_MANUAL: mode_next = pushed ? MODE_MANUAL : MODE_IDLE;
            MODE_IDLE:
            begin
                if (idle_count_reg < cfg.idle_timeout)
                begin
                    if (pushed)
                    begin
                        mode_next       = MODE_MANUAL;
                        idle_count_next = '0;
                    end
                end
                else
                begin
                    mode_next       = MODE_SWEEP;
                    idle_count_next = '0;
                end
            end
            default: mode_next = mode_reg;
        endcase

        // action taken in the mode the tick lands in
        unique case (mode_next)
            MODE_SWEEP:
            begin
                if (!sweep_down_reg)
                begin
                    position_next = up_pos;
                    if (up_clamp)
                        sweep_down_next = 1'b1;
                end
                else
                begin
                    position_next = down_pos;
                    if (down_clamp)
                        sweep_down_next = 1'b0;
                end
            end
            MODE_MANUAL:
            begin
                if (hi)
                    position_next = up_pos;
                else if (lo)
                    position_next = down_pos;
            end
            MODE_IDLE:
            begin
                if (idle_count_next != COUNT_MAX)
                    idle_count_next = idle_count_next + 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= MODE_START;
            position_reg   <= '0;
            sweep_down_reg <= 1'b0;
            idle_count_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                mode_reg       <= mode_next;
                position_reg   <= position_next;
                sweep_down_reg <= sweep_down_next;
                idle_count_reg <= idle_count_next;
                out_valid_reg  <= 1'b1;
            end
            else if (result_ch.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            out_angle_reg <= position_next;
            out_mode_reg  <= mode_next;
        end
    end

    assign result_ch.valid       = out_valid_reg;
    assign result_ch.servo_angle = out_angle_reg;
    assign result_ch.mode        = out_mode_reg;

    // the idle counter only runs in idle
    a_count_idle_only: assert property (@(posedge clk) disable iff (!rst_n)
        (mode_reg != MODE_IDLE) |-> (idle_count_reg == '0))
        else $error("idle count nonzero outside idle");

    // no word is shown before the first tick leaves start
    a_start_no_word: assert property (@(posedge clk) disable iff (!rst_n)
        (mode_reg == MODE_START) |-> !out_valid_reg)
        else $error("result word while still in start");

    // every tick taken from the queue shows up as a word with a real mode
    a_pop_word: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> (out_valid_reg && (out_mode_reg != MODE_START)
                 && (out_angle_reg == position_reg)))
        else $error("tick did not land in the result register");

endmodule

/* sim/servo_tick_checker.sv */
// Checker: predicts servo angle and mode per stick word and compares against the result channel.
module servo_tick_checker
    import svs_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                sample_valid,
    input  logic                sample_ready,
    input  logic [SAMPLE_W-1:0] stick_sample,
    input  logic                result_valid,
    input  logic                result_ready,
    input  logic [ANGLE_W-1:0]  servo_angle,
    input  logic [MODE_W-1:0]   mode,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic                pready,
    input  logic [ADDR_W-1:0]   paddr,
    input  logic [DATA_W-1:0]   pwdata,
    input  logic [DATA_W-1:0]   prdata,
    output int                  fail_count,
    output int                  pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [ANGLE_W-1:0] angle;
        logic [MODE_W-1:0]  mode;
    } servo_word_t;

    // register copy, tracked from the APB writes
    logic [SAMPLE_W-1:0] high_thr  = HIGH_THRESHOLD_RST;
    logic [SAMPLE_W-1:0] low_thr   = LOW_THRESHOLD_RST;
    logic [STEP_W-1:0]   step_deg  = ANGLE_STEP_RST;
    logic [ANGLE_W-1:0]  max_deg   = MAX_ANGLE_RST;
    logic [COUNT_W-1:0]  idle_lim  = IDLE_TIMEOUT_RST;

    // predicted controller state
    logic [MODE_W-1:0]   mode_st   = MODE_START;
    logic [ANGLE_W-1:0]  pos       = '0;
    logic                sweep_down = 1'b0;
    logic [COUNT_W-1:0]  idle_cnt  = '0;

    servo_word_t         servo_expected [$];
    servo_word_t         want;
    logic [DATA_W-1:0]   reg_rd;
    int                  mismatches = 0;

    function automatic logic at_top();
        logic [ANGLE_W:0] up_sum;
        up_sum = {1'b0, pos} + (ANGLE_W+1)'(step_deg);
        return up_sum >= {1'b0, max_deg};
    endfunction

    function automatic logic at_bottom();
        return {2'b00, pos} <= (ANGLE_W+2)'(step_deg);
    endfunction

    function automatic servo_word_t next_tick(input logic [SAMPLE_W-1:0] s);
        logic hi, lo, pushed;
        servo_word_t w;
        hi = s > high_thr;
        lo = !hi && (s < low_thr);
        pushed = hi || lo;

        case (mode_st)
            MODE_START:  mode_st = MODE_SWEEP;
            MODE_SWEEP:  if (pushed) mode_st = MODE_MANUAL;
            MODE_MANUAL: if (!pushed) mode_st = MODE_IDLE;
            default:
            begin
                if (idle_cnt < idle_lim)
                begin
                    if (pushed)
                    begin
                        mode_st = MODE_MANUAL;
                        idle_cnt = '0;
                    end
                end
                else
                begin
                    mode_st = MODE_SWEEP;
                    idle_cnt = '0;
                end
            end
        endcase

        case (mode_st)
            MODE_SWEEP:
            begin
                if (!sweep_down)
                begin
                    if (at_top())
                    begin
                        pos = max_deg;
                        sweep_down = 1'b1;
                    end
                    else
                        pos = pos + ANGLE_W'(step_deg);
                end
                else if (at_bottom())
                begin
                    pos = '0;
                    sweep_down = 1'b0;
                end
                else
                    pos = pos - ANGLE_W'(step_deg);
            end
            MODE_MANUAL:
            begin
                // direction bit is left alone in manual
                if (hi)
                    pos = at_top() ? max_deg : pos + ANGLE_W'(step_deg);
                else if (lo)
                    pos = at_bottom() ? '0 : pos - ANGLE_W'(step_deg);
            end
            MODE_IDLE:
            begin
                if (idle_cnt != COUNT_MAX)
                    idle_cnt = idle_cnt + 1'b1;
            end
            default: ;
        endcase

        w.angle = pos;
        w.mode  = mode_st;
        return w;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            high_thr   = HIGH_THRESHOLD_RST;
            low_thr    = LOW_THRESHOLD_RST;
            step_deg   = ANGLE_STEP_RST;
            max_deg    = MAX_ANGLE_RST;
            idle_lim   = IDLE_TIMEOUT_RST;
            mode_st    = MODE_START;
            pos        = '0;
            sweep_down = 1'b0;
            idle_cnt   = '0;
            servo_expected.delete();
            fail_count <= 0;
            pending    <= 0;
        end
        else
        begin
            // result first: a word accepted this edge is always older than the sample taken now
            if (result_valid && result_ready)
            begin
                if (servo_expected.size() == 0)
                begin
                    if (mismatches < 10)
                        $display("%0t: result with nothing outstanding: angle %0d mode %0d",
                                 $realtime, servo_angle, mode);
                    mismatches++;
                end
                else
                begin
                    want = servo_expected.pop_front();
                    if (servo_angle !== want.angle || mode !== want.mode)
                    begin
                        if (mismatches < 10)
                            $display("%0t: mismatch: angle exp %0d got %0d, mode exp %0d got %0d",
                                     $realtime, want.angle, servo_angle, want.mode, mode);
                        mismatches++;
                    end
                end
            end

            if (sample_valid && sample_ready)
                servo_expected.push_back(next_tick(stick_sample));

            if (psel && penable && pready)
            begin
                if (pwrite)
                begin
                    case (paddr[ADDR_W-1:2])
                        REG_HIGH_THRESHOLD: high_thr = pwdata[SAMPLE_W-1:0];
                        REG_LOW_THRESHOLD:  low_thr  = pwdata[SAMPLE_W-1:0];
                        REG_ANGLE_STEP:     step_deg = pwdata[STEP_W-1:0];
                        REG_MAX_ANGLE:      max_deg  = pwdata[ANGLE_W-1:0];
                        REG_IDLE_TIMEOUT:   idle_lim = pwdata[COUNT_W-1:0];
                        default: ;
                    endcase
                end
                else
                begin
                    case (paddr[ADDR_W-1:2])
                        REG_HIGH_THRESHOLD: reg_rd = DATA_W'(high_thr);
                        REG_LOW_THRESHOLD:  reg_rd = DATA_W'(low_thr);
                        REG_ANGLE_STEP:     reg_rd = DATA_W'(step_deg);
                        REG_MAX_ANGLE:      reg_rd = DATA_W'(max_deg);
                        default:            reg_rd = DATA_W'(idle_lim);
                    endcase
                    if (prdata !== reg_rd)
                    begin
                        if (mismatches < 10)
                            $display("%0t: register read at 0x%0h: exp 0x%0h got 0x%0h",
                                     $realtime, paddr, reg_rd, prdata);
                        mismatches++;
                    end
                end
            end

            fail_count <= mismatches;
            pending    <= servo_expected.size();
        end
    end

endmodule

/* sim/tb.sv */
// Testbench top: clock, reset, stick stimulus, register phases, result drain and verdict.
module tb;
    import svs_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int PERIOD = 10;

    logic                clk     = 1'b0;
    logic                rst_n   = 1'b0;
    logic                psel    = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite  = 1'b0;
    logic [ADDR_W-1:0]   paddr   = '0;
    logic [DATA_W-1:0]   pwdata  = '0;
    logic [DATA_W-1:0]   prdata;
    logic                pready;

    int                  fail_count;
    int                  pending;

    logic                quiet_phase  = 1'b0;
    logic                hold_request = 1'b0;

    // what the stimulus last programmed, used only to shape samples
    logic [SAMPLE_W-1:0] cur_hi = HIGH_THRESHOLD_RST;
    logic [SAMPLE_W-1:0] cur_lo = LOW_THRESHOLD_RST;
    logic [COUNT_W-1:0]  cur_timeout = IDLE_TIMEOUT_RST;

    svs_sample_if sample_ch ();
    svs_result_if result_ch ();

    servo_sweep_with_manual_override uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .sample_ch (sample_ch),
        .result_ch (result_ch),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    servo_tick_checker tick_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_ch.valid),
        .sample_ready (sample_ch.ready),
        .stick_sample (sample_ch.stick_sample),
        .result_valid (result_ch.valid),
        .result_ready (result_ch.ready),
        .servo_angle  (result_ch.servo_angle),
        .mode         (result_ch.mode),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .pready       (pready),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .fail_count   (fail_count),
        .pending      (pending)
    );

    always #(PERIOD/2) clk = ~clk;

    initial
    begin
        #(2_000_000);
        $display("servo_sweep_with_manual_override verification failed");
        $finish;
    end

    // result side: random stalls, plus one long hold-off on request
    initial
    begin : result_drain
        logic hold_seen;
        int   stall_left;
        hold_seen  = 1'b0;
        stall_left = 0;
        result_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request != hold_seen)
            begin
                hold_seen  = hold_request;
                stall_left = 80;
            end
            if (stall_left > 0)
            begin
                stall_left--;
                result_ch.ready <= 1'b0;
            end
            else
                result_ch.ready <= quiet_phase || ($urandom_range(0, 99) >= 30);
        end
    end

    task automatic send_sample(input logic [SAMPLE_W-1:0] v);
        while (!quiet_phase && $urandom_range(0, 99) < 30)
        begin
            sample_ch.valid <= 1'b0;
            @(posedge clk);
        end
        sample_ch.valid        <= 1'b1;
        sample_ch.stick_sample <= v;
        do @(posedge clk); while (!sample_ch.ready);
    endtask

    // one transfer; psel stays up so the next call can follow straight on
    task automatic apb_access(input logic wr, input logic [2:0] idx,
                              input logic [DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
    endtask

    task automatic program_regs(input logic [SAMPLE_W-1:0] hi, input logic [SAMPLE_W-1:0] lo,
                                input logic [STEP_W-1:0] step, input logic [ANGLE_W-1:0] top,
                                input logic [COUNT_W-1:0] tmo);
        apb_access(1'b1, REG_HIGH_THRESHOLD, DATA_W'(hi));
        apb_access(1'b1, REG_LOW_THRESHOLD,  DATA_W'(lo));
        apb_access(1'b1, REG_ANGLE_STEP,     DATA_W'(step));
        apb_access(1'b1, REG_MAX_ANGLE,      DATA_W'(top));
        apb_access(1'b1, REG_IDLE_TIMEOUT,   DATA_W'(tmo));
        apb_access(1'b0, REG_HIGH_THRESHOLD, '0);
        apb_access(1'b0, REG_LOW_THRESHOLD,  '0);
        apb_access(1'b0, REG_ANGLE_STEP,     '0);
        apb_access(1'b0, REG_MAX_ANGLE,      '0);
        apb_access(1'b0, REG_IDLE_TIMEOUT,   '0);
        psel        <= 1'b0;
        penable     <= 1'b0;
        cur_hi      = hi;
        cur_lo      = lo;
        cur_timeout = tmo;
    endtask

    // drop valid and let every outstanding word come back
    task automatic finish_phase();
        sample_ch.valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (2) @(posedge clk);
    endtask

    // runs of centred, pushed-high and pushed-low words, with some noise between
    task automatic drive_random(input int count);
        int                  sent;
        int                  kind;
        int                  run_len;
        int                  k;
        logic [SAMPLE_W-1:0] v;
        sent = 0;
        while (sent < count)
        begin
            kind = $urandom_range(0, 9);
            if (kind == 0)
                run_len = 1;
            else if (kind <= 3)
                run_len = $urandom_range(0, 1) ? $urandom_range(1, int'(cur_timeout) + 3)
                                               : $urandom_range(1, 3);
            else
                run_len = $urandom_range(1, 8);
            for (k = 0; k < run_len && sent < count; k++)
            begin
                case (kind)
                    0: v = SAMPLE_W'($urandom);
                    1, 2, 3:
                        v = (cur_lo <= cur_hi) ? SAMPLE_W'($urandom_range(cur_lo, cur_hi))
                                               : SAMPLE_W'($urandom);
                    4, 5, 6:
                        v = (cur_hi != '1) ? SAMPLE_W'($urandom_range(cur_hi + 1, 1023)) : '1;
                    default:
                        v = (cur_lo != '0) ? SAMPLE_W'($urandom_range(0, cur_lo - 1)) : '0;
                endcase
                send_sample(v);
                sent++;
            end
        end
    endtask

    initial
    begin : stimulus
        logic [SAMPLE_W-1:0] dir_reset [12] = '{0, 1023, 1023, 0, 512, 512, 0,
                                                601, 600, 400, 399, 512};
        logic [SAMPLE_W-1:0] dir_climb [8]  = '{1023, 1023, 1023, 1023, 1023, 1023, 512, 512};
        logic [SAMPLE_W-1:0] dir_edge [3]   = '{500, 0, 1023};
        logic [SAMPLE_W-1:0] r_hi;
        logic [SAMPLE_W-1:0] r_lo;
        logic [STEP_W-1:0]   r_step;
        logic [ANGLE_W-1:0]  r_top;
        logic [COUNT_W-1:0]  r_tmo;
        int                  ph;

        sample_ch.valid        = 1'b0;
        sample_ch.stick_sample = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset defaults: start, sweep, both pushes, centre, threshold boundaries
        foreach (dir_reset[i]) send_sample(dir_reset[i]);
        finish_phase();

        // big step, full travel, zero timeout
        program_regs(10'd600, 10'd400, 6'd45, 8'd255, 8'd0);
        foreach (dir_climb[i]) send_sample(dir_climb[i]);
        finish_phase();

        // angle above a shrunken max, zero step, overlapping thresholds (high wins)
        program_regs(10'd100, 10'd900, 6'd0, 8'd1, 8'd255);
        foreach (dir_edge[i]) send_sample(dir_edge[i]);
        finish_phase();

        // nothing ever pushed
        program_regs(10'd1023, 10'd0, 6'd1, 8'd255, 8'd0);
        foreach (dir_edge[i]) send_sample(dir_edge[i]);
        finish_phase();

        for (ph = 0; ph < 8; ph++)
        begin
            case (ph)
                0: program_regs(HIGH_THRESHOLD_RST, LOW_THRESHOLD_RST, ANGLE_STEP_RST,
                                MAX_ANGLE_RST, IDLE_TIMEOUT_RST);
                1: program_regs(10'd1023, 10'd0, 6'd45, 8'd255, 8'd255);
                2: program_regs(10'd0, 10'd1023, 6'd63, 8'd0, 8'd0);
                3: program_regs(10'd512, 10'd511, 6'd1, 8'd255, 8'd3);
                default:
                begin
                    r_hi   = SAMPLE_W'($urandom_range(0, 1023));
                    r_lo   = ($urandom_range(0, 4) == 0) ? SAMPLE_W'($urandom_range(0, 1023))
                                                         : SAMPLE_W'($urandom_range(0, r_hi));
                    r_step = ($urandom_range(0, 3) == 0) ? STEP_W'($urandom_range(0, 63))
                                                         : STEP_W'($urandom_range(1, 45));
                    r_top  = ANGLE_W'($urandom_range(0, 255));
                    r_tmo  = ($urandom_range(0, 4) == 0) ? COUNT_W'($urandom_range(0, 255))
                                                         : COUNT_W'($urandom_range(0, 30));
                    program_regs(r_hi, r_lo, r_step, r_top, r_tmo);
                end
            endcase

            quiet_phase = (ph == 3);
            if (ph == 5)
            begin
                // long result hold-off while words keep coming
                drive_random(30);
                hold_request <= ~hold_request;
                drive_random(150);
            end
            else
                drive_random(180);
            finish_phase();
            quiet_phase = 1'b0;
        end

        repeat (8) @(posedge clk);
        if (fail_count == 0)
            $display("servo_sweep_with_manual_override verification clean");
        else
            $display("servo_sweep_with_manual_override verification failed");
        $finish;
    end

endmodule
